>>> hdl/ddkq_pkg.sv
// Shared constants, codes and types for the dual-direction key qualifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ddkq_pkg;

    // Hold counter width and its saturation value
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration register widths
    localparam int KEYS_W  = 2;
    localparam int TICKS_W = 16;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 2;

    // Width used when a hold count is compared against a tick limit
    localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

    // Stream word widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // Register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_ALLOWED_KEYS = 2'd0;
    localparam logic [ADDR_W-1:0] REG_MIN_PRESS    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_STUCK_PRESS  = 2'd2;

    // Key selection codes
    localparam logic [KEYS_W-1:0] KEYS_BOTH      = 2'd0;
    localparam logic [KEYS_W-1:0] KEYS_UP_ONLY   = 2'd1;
    localparam logic [KEYS_W-1:0] KEYS_DOWN_ONLY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [KEYS_W-1:0]  ALLOWED_KEYS_RST = KEYS_BOTH;
    localparam logic [TICKS_W-1:0] MIN_PRESS_RST    = 16'd10;
    localparam logic [TICKS_W-1:0] STUCK_PRESS_RST  = 16'd500;

    // Events reported by one press tracker for one word
    typedef struct packed {
        logic both_keys;
        logic stuck;
        logic run_order;
        logic reset_request;
    } track_event_t;

    // Tick limits handed to each tracker
    typedef struct packed {
        logic [TICKS_W-1:0] min_press;
        logic [TICKS_W-1:0] stuck_press;
    } track_limits_t;

endpackage

`default_nettype wire

>>> hdl/ddkq_tracker.sv
// One press tracker: idle/held flag and saturating hold counter for one key.
// Depends on ddkq_pkg for widths and the event/limit structs.
`default_nettype none

module ddkq_tracker
    import ddkq_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic          enable,
    input  wire logic          key,
    input  wire logic          other_key,
    input  wire logic          fault_state,
    input  wire track_limits_t limits,
    output track_event_t       events
);

    logic                   held_reg;
    logic                   held_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_cmp;
    logic [CMP_W-1:0]       min_cmp;
    logic [CMP_W-1:0]       stuck_cmp;

    // Saturating increment and widened operands for the limit compares
    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign count_cmp = CMP_W'(count_inc);
    assign min_cmp   = CMP_W'(limits.min_press);
    assign stuck_cmp = CMP_W'(limits.stuck_press);

    // Work out the next tracker state and this word's events
    always_comb begin
        held_next  = held_reg;
        count_next = count_reg;
        events     = '0;
        if (enable) begin
            if (!held_reg) begin
                if (key) begin
                    if (!other_key) begin
                        count_next = '0;
                        held_next  = 1'b1;
                    end else begin
                        events.both_keys = 1'b1;
                    end
                end
            end else begin
                count_next = count_inc;
                held_next  = 1'b0;
                if (key) begin
                    if (other_key) begin
                        events.both_keys = 1'b1;
                    end else if (count_cmp > stuck_cmp) begin
                        events.stuck = 1'b1;
                    end else begin
                        held_next = 1'b1;
                    end
                end else if (count_cmp > min_cmp) begin
                    count_next = '0;
                    if (fault_state) begin
                        events.reset_request = 1'b1;
                    end else begin
                        events.run_order = 1'b1;
                    end
                end
            end
        end
    end

    // Advance tracker state once per processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            count_reg <= '0;
        end else if (step) begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dual_direction_key_qualifier_unit.sv
// Top level of the dual-direction key qualifier: stream ports, config
// registers, input and result registers. Uses ddkq_pkg and ddkq_tracker.
//
// Usage:
//   Each input word on the s_ channel is one system tick carrying the up and
//   down key levels, the fault-state flag and the safety-end enable. For every
//   accepted word exactly one result word leaves on the m_ channel with the
//   latched run orders and the fault/reset pulses for that tick.
//   Path: a word accepted on the s_ channel is captured in the input register,
//   is evaluated against tracker state in one pass and is registered in the
//   result register before it shows on m_tdata (two register stages).
//   Throughput: one word per cycle while m_tready is high; s_tready stays
//   high while the result register is free or being drained, so a new word
//   is taken while a result waits to be picked up.
//   Stall: when m_tready is low with a result pending, the result holds, the
//   input register holds one more word and then s_tready drops.
//   Reset (aresetn low, synchronous): both trackers idle with zero counts,
//   run orders cleared, both registers empty, config back to allowed_keys 0,
//   min_press_ticks 10, stuck_press_ticks 500.
//   Config writes on cfg_wr_en take effect at once and belong in idle time.
`default_nettype none

module dual_direction_key_qualifier_unit
    import ddkq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [ADDR_W-1:0]     cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // Tick input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // up_key_pressed, down_key_pressed, in_fault_state, safety_end_enabled, pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // Result output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // run_up, run_down, fault_both_keys, fault_up_stuck, fault_down_stuck,
    // fault_reset_request, pad
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [KEYS_W-1:0]  allowed_keys_reg;
    logic [TICKS_W-1:0] min_press_reg;
    logic [TICKS_W-1:0] stuck_press_reg;

    logic               in_valid_reg;
    logic               in_up_reg;
    logic               in_down_reg;
    logic               in_fault_reg;
    logic               in_safety_reg;

    logic               out_valid_reg;
    logic [5:0]         out_bits_reg;
    logic [5:0]         out_bits_next;

    logic               run_up_reg;
    logic               run_down_reg;
    logic               run_up_next;
    logic               run_down_next;

    logic               advance;
    logic               step;
    logic               up_en;
    logic               down_en;
    track_limits_t      limits;
    track_event_t       up_ev;
    track_event_t       down_ev;

    // Handshake: the result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allowed_keys_reg <= ALLOWED_KEYS_RST;
            min_press_reg    <= MIN_PRESS_RST;
            stuck_press_reg  <= STUCK_PRESS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ALLOWED_KEYS: allowed_keys_reg <= cfg_wdata[KEYS_W-1:0];
                REG_MIN_PRESS:    min_press_reg    <= cfg_wdata[TICKS_W-1:0];
                REG_STUCK_PRESS:  stuck_press_reg  <= cfg_wdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_up_reg     <= s_tdata[0];
            in_down_reg   <= s_tdata[1];
            in_fault_reg  <= s_tdata[2];
            in_safety_reg <= s_tdata[3];
        end
    end

    // Tracker selection and limits
    assign up_en   = (allowed_keys_reg == KEYS_BOTH) || (allowed_keys_reg == KEYS_UP_ONLY);
    assign down_en = (allowed_keys_reg == KEYS_BOTH) || (allowed_keys_reg == KEYS_DOWN_ONLY);
    assign limits.min_press   = min_press_reg;
    assign limits.stuck_press = stuck_press_reg;

    ddkq_tracker u_up_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .enable      (up_en),
        .key         (in_up_reg),
        .other_key   (in_down_reg),
        .fault_state (in_fault_reg),
        .limits      (limits),
        .events      (up_ev)
    );

    ddkq_tracker u_down_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .enable      (down_en),
        .key         (in_down_reg),
        .other_key   (in_up_reg),
        .fault_state (in_fault_reg),
        .limits      (limits),
        .events      (down_ev)
    );

    // Latch run orders on valid releases, drop them without safety-end
    assign run_up_next   = in_safety_reg && (run_up_reg || up_ev.run_order);
    assign run_down_next = in_safety_reg && (run_down_reg || down_ev.run_order);

    assign out_bits_next = {
        up_ev.reset_request || down_ev.reset_request,
        down_ev.stuck,
        up_ev.stuck,
        up_ev.both_keys || down_ev.both_keys,
        run_down_next,
        run_up_next
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_up_reg   <= 1'b0;
            run_down_reg <= 1'b0;
        end else if (step) begin
            run_up_reg   <= run_up_next;
            run_down_reg <= run_down_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_bits_reg <= out_bits_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_bits_reg};

endmodule

`default_nettype wire

>>> hdl/ddkq_checker.sv
// Port-level checks for dual_direction_key_qualifier_unit, bound to the top.
// Depends on ddkq_pkg for stream widths.
`default_nettype none

module ddkq_checker
    import ddkq_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present right after reset");

    // A stalled result word stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // A both-keys fault and a stuck fault cannot come from the same tick
    a_fault_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[3] && !m_tdata[4])
        else $error("both-keys fault together with a stuck fault");

    // Pad bits of the result word stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("nonzero pad bits in result word");

endmodule

bind dual_direction_key_qualifier_unit ddkq_checker u_ddkq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the dual-direction key qualifier stream block.
// Needs ddkq_pkg and dual_direction_key_qualifier_unit; runs directed ticks,
// a long hold with the stuck check out of reach, and random key sequences under stalls.
module tb_top;
    import ddkq_pkg::*;

    // Key selection code with neither tracker working
    localparam logic [KEYS_W-1:0] KEYS_NONE = 2'd3;
    localparam int TIMEOUT_CYCLES = 700000;
    localparam int REPORT_LIMIT   = 10;

    // One tick word, lowest bit first: up, down, fault state, safety end
    typedef struct packed {
        logic safety_on;
        logic fault_state;
        logic down_key;
        logic up_key;
    } tick_in_t;

    // One result word, lowest bit first
    typedef struct packed {
        logic fault_reset_request;
        logic fault_down_stuck;
        logic fault_up_stuck;
        logic fault_both_keys;
        logic run_down;
        logic run_up;
    } tick_result_t;

    localparam tick_result_t RES_QUIET     = 6'b000000;
    localparam tick_result_t RES_RUN_UP    = 6'b000001;
    localparam tick_result_t RES_BOTH_KEYS = 6'b000100;
    localparam tick_result_t RES_UP_STUCK  = 6'b001000;
    localparam tick_result_t RES_RESET_REQ = 6'b100000;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [CFG_W-1:0]  value;
        tick_in_t          tick;
        logic              typed;
        tick_result_t      result;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [ADDR_W-1:0]     cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Key qualifier model state and its copy of the registers
    logic [KEYS_W-1:0]      keys_sel;
    logic [TICKS_W-1:0]     min_ticks;
    logic [TICKS_W-1:0]     stuck_ticks;
    logic                   up_is_held;
    logic [COUNT_WIDTH-1:0] up_ticks_held;
    logic                   down_is_held;
    logic [COUNT_WIDTH-1:0] down_ticks_held;
    logic                   run_up_latched;
    logic                   run_down_latched;

    tick_result_t  pending_results[$];
    directed_row_t directed_rows[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    dual_direction_key_qualifier_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Advance one press tracker by one tick and report its events
    function automatic track_event_t step_tracker(inout logic held,
                                                  inout logic [COUNT_WIDTH-1:0] ticks,
                                                  input logic key, input logic other,
                                                  input logic fault);
        track_event_t ev;
        ev = '0;
        if (!held) begin
            if (key) begin
                if (!other) begin
                    ticks = '0;
                    held  = 1'b1;
                end else begin
                    ev.both_keys = 1'b1;
                end
            end
        end else begin
            // Saturate rather than wrap
            if (ticks != COUNT_MAX)
                ticks = ticks + 1'b1;
            if (key) begin
                if (!other) begin
                    if (ticks > stuck_ticks) begin
                        held     = 1'b0;
                        ev.stuck = 1'b1;
                    end
                end else begin
                    held         = 1'b0;
                    ev.both_keys = 1'b1;
                end
            end else begin
                held = 1'b0;
                if (ticks > min_ticks) begin
                    ticks = '0;
                    if (fault)
                        ev.reset_request = 1'b1;
                    else
                        ev.run_order = 1'b1;
                end
            end
        end
        return ev;
    endfunction

    // Work out the result word of one tick, up tracker first
    function automatic tick_result_t qualify_tick(input tick_in_t t);
        track_event_t up_ev;
        track_event_t down_ev;
        tick_result_t r;
        up_ev   = '0;
        down_ev = '0;
        if (keys_sel == KEYS_BOTH || keys_sel == KEYS_UP_ONLY)
            up_ev = step_tracker(up_is_held, up_ticks_held, t.up_key, t.down_key,
                                 t.fault_state);
        if (keys_sel == KEYS_BOTH || keys_sel == KEYS_DOWN_ONLY)
            down_ev = step_tracker(down_is_held, down_ticks_held, t.down_key, t.up_key,
                                   t.fault_state);
        if (up_ev.run_order)
            run_up_latched = 1'b1;
        if (down_ev.run_order)
            run_down_latched = 1'b1;
        if (!t.safety_on) begin
            run_up_latched   = 1'b0;
            run_down_latched = 1'b0;
        end
        r.run_up              = run_up_latched;
        r.run_down            = run_down_latched;
        r.fault_both_keys     = up_ev.both_keys | down_ev.both_keys;
        r.fault_up_stuck      = up_ev.stuck;
        r.fault_down_stuck    = down_ev.stuck;
        r.fault_reset_request = up_ev.reset_request | down_ev.reset_request;
        return r;
    endfunction

    function automatic string field_name(input int i);
        case (i)
            0: return "run_up";
            1: return "run_down";
            2: return "fault_both_keys";
            3: return "fault_up_stuck";
            4: return "fault_down_stuck";
            default: return "fault_reset_request";
        endcase
    endfunction

    // Offer one word, hold it until taken, then queue its expected result
    task automatic send_tick(input tick_in_t t, input logic typed,
                             input tick_result_t typed_res);
        tick_result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 4){1'b0}}, t};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = qualify_tick(t);
        pending_results.push_back(typed ? typed_res : predicted);
        ticks_sent++;
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        case (addr)
            REG_ALLOWED_KEYS: keys_sel    = value[KEYS_W-1:0];
            REG_MIN_PRESS:    min_ticks   = value[TICKS_W-1:0];
            REG_STUCK_PRESS:  stuck_ticks = value[TICKS_W-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic add_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        directed_row_t row;
        row = '{ROW_WRITE, addr, value, '0, 1'b0, RES_QUIET};
        directed_rows.push_back(row);
    endtask

    task automatic add_tick(input logic up, input logic down, input logic fault,
                            input logic safety, input logic typed,
                            input tick_result_t res);
        directed_row_t row;
        row = '{ROW_TICK, REG_ALLOWED_KEYS, '0, {safety, fault, down, up}, typed, res};
        directed_rows.push_back(row);
    endtask

    // Random key sequences: mostly press-hold-release, some noise
    task automatic run_random_phase(input int n_ticks);
        int          start_count;
        int          kind;
        int          hold;
        int          hold_cap;
        int          reps;
        logic        press_up;
        logic        safety;
        logic        fault;
        tick_in_t    t;
        start_count = ticks_sent;
        while (ticks_sent - start_count < n_ticks) begin
            kind   = $urandom_range(0, 9);
            safety = ($urandom_range(0, 9) != 0);
            fault  = ($urandom_range(0, 3) == 0);
            if (kind <= 5) begin
                press_up = 1'($urandom_range(0, 1));
                hold_cap = (stuck_ticks < 20) ? int'(stuck_ticks) + 3 : 24;
                hold     = $urandom_range(0, hold_cap);
                for (int i = 0; i <= hold; i++) begin
                    t.up_key      = press_up;
                    t.down_key    = !press_up;
                    if ($urandom_range(0, 19) == 0) begin
                        t.up_key   = 1'b1;
                        t.down_key = 1'b1;
                    end
                    t.fault_state = fault;
                    t.safety_on   = safety;
                    send_tick(t, 1'b0, RES_QUIET);
                end
                reps = $urandom_range(1, 2);
                for (int i = 0; i < reps; i++)
                    send_tick({safety, fault, 1'b0, 1'b0}, 1'b0, RES_QUIET);
            end else if (kind <= 7) begin
                reps = $urandom_range(1, 4);
                for (int i = 0; i < reps; i++)
                    send_tick(tick_in_t'(4'($urandom_range(0, 15))), 1'b0, RES_QUIET);
            end else if (kind == 8) begin
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++)
                    send_tick({safety, fault, 1'b1, 1'b1}, 1'b0, RES_QUIET);
            end else begin
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++)
                    send_tick({1'(($urandom_range(0, 1))), fault, 1'b0, 1'b0}, 1'b0,
                              RES_QUIET);
            end
        end
    endtask

    // Check each result word against the oldest expectation
    always @(posedge aclk) begin
        tick_result_t want;
        tick_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = tick_result_t'(m_tdata[5:0]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word %b at cycle %0d", got, cycle_count);
            end else begin
                want = pending_results.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (want[i] !== got[i]) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result %0d %s: expected %b, got %b", results_checked,
                                     field_name(i), want[i], got[i]);
                    end
                end
                results_checked++;
            end
        end
        m_tready <= aresetn ? ($urandom_range(0, 99) >= recv_stall_pct) : 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int idle_mode;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_ALLOWED_KEYS;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        keys_sel         = ALLOWED_KEYS_RST;
        min_ticks        = MIN_PRESS_RST;
        stuck_ticks      = STUCK_PRESS_RST;
        up_is_held       = 1'b0;
        up_ticks_held    = '0;
        down_is_held     = 1'b0;
        down_ticks_held  = '0;
        run_up_latched   = 1'b0;
        run_down_latched = 1'b0;

        // Directed ticks, reset limits first
        add_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, RES_QUIET);
        add_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, RES_BOTH_KEYS);
        add_write(REG_MIN_PRESS, 16'd0);
        add_write(REG_STUCK_PRESS, 16'd2);
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, RES_RUN_UP);
        add_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, RES_QUIET);
        add_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, RES_RESET_REQ);
        // Hold up past the stuck limit, then restart the hold
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, RES_UP_STUCK);
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, RES_BOTH_KEYS);
        add_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        // Short release only drops the tracker
        add_write(REG_MIN_PRESS, 16'd5);
        add_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_write(REG_MIN_PRESS, 16'd0);
        add_write(REG_ALLOWED_KEYS, CFG_W'(KEYS_UP_ONLY));
        add_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, RES_BOTH_KEYS);
        add_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, RES_RUN_UP);
        add_write(REG_ALLOWED_KEYS, CFG_W'(KEYS_DOWN_ONLY));
        add_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, RES_QUIET);
        // No tracker works; only the safety clear acts
        add_write(REG_ALLOWED_KEYS, CFG_W'(KEYS_NONE));
        add_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, RES_QUIET);
        add_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, RES_QUIET);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(directed_rows[i].addr, directed_rows[i].value);
            end else begin
                send_tick(directed_rows[i].tick, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        // Long hold of up with the stuck limit at its top value, then a valid release
        drain_results();
        write_reg(REG_ALLOWED_KEYS, CFG_W'(KEYS_BOTH));
        write_reg(REG_MIN_PRESS, 16'd30);
        write_reg(REG_STUCK_PRESS, 16'd65535);
        for (int i = 0; i < 40; i++)
            send_tick({1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, RES_QUIET);
        send_tick({1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET);

        // Random phases, idling pattern rotating, limits changed in between
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            if (phase == 0) begin
                write_reg(REG_ALLOWED_KEYS, CFG_W'(KEYS_BOTH));
                write_reg(REG_MIN_PRESS, 16'd0);
                write_reg(REG_STUCK_PRESS, 16'd1);
            end else if (phase == 7) begin
                write_reg(REG_ALLOWED_KEYS, CFG_W'($urandom_range(0, 3)));
                write_reg(REG_MIN_PRESS, 16'd65535);
                write_reg(REG_STUCK_PRESS, 16'd65535);
            end else begin
                case ($urandom_range(0, 5))
                    3: write_reg(REG_ALLOWED_KEYS, CFG_W'(KEYS_UP_ONLY));
                    4: write_reg(REG_ALLOWED_KEYS, CFG_W'(KEYS_DOWN_ONLY));
                    5: write_reg(REG_ALLOWED_KEYS, CFG_W'(KEYS_NONE));
                    default: write_reg(REG_ALLOWED_KEYS, CFG_W'(KEYS_BOTH));
                endcase
                write_reg(REG_MIN_PRESS, CFG_W'($urandom_range(0, 6)));
                write_reg(REG_STUCK_PRESS, CFG_W'($urandom_range(1, 15)));
            end
            idle_mode = phase % 4;
            case (idle_mode)
                1: begin
                    sender_idle_pct = 67;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 67;
                end
                3: begin
                    sender_idle_pct = 11;
                    recv_stall_pct  = 11;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
            endcase
            run_random_phase(85);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("tb_top: %0d ticks sent, %0d results checked, %0d register writes",
                 ticks_sent, results_checked, reg_writes);
        $display("covered all key selections, limit extremes, long holds, stalls");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d failures, %0d results outstanding", mismatches,
                     pending_results.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
